// ===== rtl/psl_pkg.sv =====
// Shared types, constants and command codes for the pairwise slope line fit core.
package psl_pkg;

   // Default sizes
   localparam int MAX_POINTS_DEF   = 16;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // Iterative unit widths
   localparam int DIV_W  = 64;
   localparam int SQRT_W = 64;

   // Reset value of the t factor, 2.365 in Q4.12
   localparam logic [15:0] T_COEF_RESET = 16'd9687;

   // Fit status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ODD     = 3'd1;
   localparam logic [2:0] ST_FEW     = 3'd2;
   localparam logic [2:0] ST_ZERO_DX = 3'd3;
   localparam logic [2:0] ST_OVF     = 3'd4;

   // Datapath commands
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_W-1:0] OP_INIT      = 5'd2;
   localparam logic [OP_W-1:0] OP_PAIR_RD   = 5'd3;
   localparam logic [OP_W-1:0] OP_PAIR_DIV  = 5'd4;
   localparam logic [OP_W-1:0] OP_PAIR_END  = 5'd5;
   localparam logic [OP_W-1:0] OP_A_DIV     = 5'd6;
   localparam logic [OP_W-1:0] OP_A_END     = 5'd7;
   localparam logic [OP_W-1:0] OP_SQ_RD     = 5'd8;
   localparam logic [OP_W-1:0] OP_SQ_MUL    = 5'd9;
   localparam logic [OP_W-1:0] OP_SQ_ACC    = 5'd10;
   localparam logic [OP_W-1:0] OP_VAR_DIV   = 5'd11;
   localparam logic [OP_W-1:0] OP_VAR_SQRT  = 5'd12;
   localparam logic [OP_W-1:0] OP_DA_MUL    = 5'd13;
   localparam logic [OP_W-1:0] OP_DA        = 5'd14;
   localparam logic [OP_W-1:0] OP_XM_DIV    = 5'd15;
   localparam logic [OP_W-1:0] OP_XM_END    = 5'd16;
   localparam logic [OP_W-1:0] OP_YM_DIV    = 5'd17;
   localparam logic [OP_W-1:0] OP_YM_END    = 5'd18;
   localparam logic [OP_W-1:0] OP_B_MUL     = 5'd19;
   localparam logic [OP_W-1:0] OP_B         = 5'd20;
   localparam logic [OP_W-1:0] OP_MSQ_DIV   = 5'd21;
   localparam logic [OP_W-1:0] OP_MSQ_SQRT  = 5'd22;
   localparam logic [OP_W-1:0] OP_DB_MUL    = 5'd23;
   localparam logic [OP_W-1:0] OP_FINISH    = 5'd24;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
      logic pre_bad;
      logic dx_zero;
      logic idx_last;
   } sts_type;

endpackage

// ===== rtl/psl_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module psl_div
   import psl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic [DIV_W-1:0] quo,
   output logic             done
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   rem_sh;
   logic             ge;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W - 1);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ===== rtl/psl_sqrt.sv =====
// Floor integer square root, one root bit per cycle.
module psl_sqrt
   import psl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SQRT_W-1:0]   radicand,
   output logic [SQRT_W/2-1:0] root,
   output logic                done
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SQRT_W-1:0] v_ff, v_in;
   logic [SQRT_W-1:0] res_ff, res_in;
   logic [SQRT_W-1:0] bit_ff, bit_in;
   logic [SQRT_W-1:0] trial;

   // Try the next root bit against the remaining radicand
   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = radicand;
         res_in  = '0;
         bit_in  = SQRT_W'(1) << (SQRT_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SQRT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[SQRT_W/2-1:0];
   assign done = done_ff;

endmodule

// ===== rtl/psl_datapath.sv =====
// Point stores, accumulators, shared divider and root unit, result registers.
module psl_datapath
   import psl_pkg::*;
#(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output sts_type                        sts,
   input  logic signed [SAMPLE_WIDTH-1:0] req_x_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_y_sample,
   input  logic                           csr_wr_en,
   input  logic [15:0]                    csr_wr_data,
   output logic signed [31:0]             rsp_slope,
   output logic [30:0]                    rsp_slope_error,
   output logic signed [31:0]             rsp_intercept,
   output logic [30:0]                    rsp_intercept_error,
   output logic [2:0]                     rsp_fit_status
);

   localparam int XS  = SAMPLE_WIDTH;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int SD  = MAX_POINTS / 2;
   localparam int SAW = $clog2(SD);
   localparam int MW  = XS + 9;
   localparam int PW  = (XS + 40 > 64) ? XS + 40 : 64;
   localparam int X2W = 2 * XS + CW;
   localparam int X2E = (X2W > 64) ? X2W : 65;
   localparam int SSW = 64 + CW;

   // Memories
   logic signed [XS-1:0] x_mem [MAX_POINTS];
   logic signed [XS-1:0] y_mem [MAX_POINTS];
   logic signed [31:0]   s_mem [SD];

   // Registers
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic [SAW-1:0]        idx_ff, idx_in;
   logic [15:0]           t_ff, t_in;
   logic signed [XS-1:0]  xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic signed [31:0]    srd_ff;
   logic signed [31+CW:0] sum_a_ff, sum_a_in;
   logic [SSW-1:0]        sum_sq_ff, sum_sq_in;
   logic signed [XS+CW-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [X2W-1:0]        sum_x2_ff, sum_x2_in;
   logic [2*XS-1:0]       sqlo_ff, sqlo_in, sqhi_ff, sqhi_in;
   logic                  neg_ff, neg_in;
   logic                  pneg_ff, pneg_in;
   logic signed [MW-1:0]  xm_ff, xm_in, ym_ff, ym_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic                  ov_ff, ov_in;
   logic [2:0]            status_ff, status_in;
   logic signed [31:0]    slope_ff, slope_in;
   logic [30:0]           serr_ff, serr_in;
   logic signed [31:0]    icpt_ff, icpt_in;
   logic [30:0]           ierr_ff, ierr_in;
   logic [2:0]            fst_ff, fst_in;

   // Unit handshakes
   logic                  div_start, div_done;
   logic [DIV_W-1:0]      div_num, div_den, div_quo;
   logic                  sq_start, sq_done;
   logic [SQRT_W-1:0]     sq_in;
   logic [SQRT_W/2-1:0]   sq_root;

   // Combinational helpers
   logic [CW-1:0]         m_w;
   logic [AW-1:0]         lo_addr, hi_addr;
   logic [2:0]            pre_code;
   logic signed [XS:0]    dx, dy;
   logic [XS:0]           dx_mag, dy_mag;
   logic [XS-1:0]         xlo_mag, xhi_mag;
   logic [32:0]           sl_sat;
   logic signed [31:0]    sl;
   logic [31+CW:0]        sa_mag;
   logic signed [32:0]    diff;
   logic [31:0]           dmag;
   logic [63:0]           dsq;
   logic [2*CW-1:0]       mm;
   logic [X2E-1:0]        x2e;
   logic [XS+CW-1:0]      sx_mag, sy_mag;
   logic [31:0]           amag;
   logic [MW-2:0]         xmag;
   logic [62:0]           pcap;
   logic [46:0]           p16;
   logic signed [63:0]    ps, bdiff;
   logic [PW-13:0]        v12;
   logic [PW-17:0]        v16;

   // Saturate a signed magnitude to 32 bits, flag in the top bit
   function automatic logic [32:0] sat_s32(input logic neg, input logic [DIV_W-1:0] mag);
      logic [32:0] r;
      if (!neg) begin
         if (mag > DIV_W'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
         else                             r = {1'b0, mag[31:0]};
      end else begin
         if (mag > DIV_W'(32'h8000_0000)) r = {1'b1, 32'h8000_0000};
         else                             r = {1'b0, 32'(-mag[31:0])};
      end
      return r;
   endfunction

   // Addresses, precheck and arithmetic helpers
   always_comb begin
      m_w      = {1'b0, cnt_ff[CW-1:1]};
      lo_addr  = AW'(idx_ff);
      hi_addr  = AW'(cnt_ff - CW'(1) - CW'(idx_ff));
      if (ovf_ff)                 pre_code = ST_OVF;
      else if (cnt_ff[0])         pre_code = ST_ODD;
      else if (cnt_ff < CW'(4))   pre_code = ST_FEW;
      else                        pre_code = ST_OK;
      dx      = $signed({xhi_ff[XS-1], xhi_ff}) - $signed({xlo_ff[XS-1], xlo_ff});
      dy      = $signed({yhi_ff[XS-1], yhi_ff}) - $signed({ylo_ff[XS-1], ylo_ff});
      dx_mag  = dx[XS] ? (XS+1)'(-dx) : dx;
      dy_mag  = dy[XS] ? (XS+1)'(-dy) : dy;
      xlo_mag = xlo_ff[XS-1] ? XS'(-xlo_ff) : xlo_ff;
      xhi_mag = xhi_ff[XS-1] ? XS'(-xhi_ff) : xhi_ff;
      sl_sat  = sat_s32(neg_ff, div_quo);
      sl      = sl_sat[31:0];
      sa_mag  = sum_a_ff[31+CW] ? (32+CW)'(-sum_a_ff) : sum_a_ff;
      diff    = 33'(srd_ff) - 33'(slope_ff);
      dmag    = diff[32] ? 32'(-diff) : diff[31:0];
      dsq     = dmag * dmag;
      mm      = m_w * (m_w - CW'(1));
      x2e     = X2E'(sum_x2_ff);
      sx_mag  = sum_x_ff[XS+CW-1] ? (XS+CW)'(-sum_x_ff) : sum_x_ff;
      sy_mag  = sum_y_ff[XS+CW-1] ? (XS+CW)'(-sum_y_ff) : sum_y_ff;
      amag    = slope_ff[31] ? 32'(-slope_ff) : slope_ff;
      xmag    = xm_ff[MW-1] ? (MW-1)'(-xm_ff) : xm_ff[MW-2:0];
      pcap    = (prod_ff > PW'(64'h4000_0000_0000_0000)) ? 63'h4000_0000_0000_0000
                                                         : prod_ff[62:0];
      p16     = pcap[62:16];
      ps      = pneg_ff ? -$signed(64'(p16)) : $signed(64'(p16));
      bdiff   = 64'(ym_ff) - ps;
      v12     = prod_ff[PW-1:12];
      v16     = prod_ff[PW-1:16];
   end

   // Next-state logic per command
   always_comb begin
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      t_in      = csr_wr_en ? csr_wr_data : t_ff;
      sum_a_in  = sum_a_ff;
      sum_sq_in = sum_sq_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_x2_in = sum_x2_ff;
      sqlo_in   = sqlo_ff;
      sqhi_in   = sqhi_ff;
      neg_in    = neg_ff;
      pneg_in   = pneg_ff;
      xm_in     = xm_ff;
      ym_in     = ym_ff;
      prod_in   = prod_ff;
      ov_in     = ov_ff;
      status_in = status_ff;
      slope_in  = slope_ff;
      serr_in   = serr_ff;
      icpt_in   = icpt_ff;
      ierr_in   = ierr_ff;
      fst_in    = fst_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      sq_start  = 1'b0;
      sq_in     = '0;
      unique case (cmd.op)
         OP_LOAD: begin
            if (cnt_ff == CW'(MAX_POINTS)) ovf_in = 1'b1;
            else                           cnt_in = cnt_ff + CW'(1);
         end
         OP_INIT: begin
            status_in = pre_code;
            ov_in     = 1'b0;
            idx_in    = '0;
            sum_a_in  = '0;
            sum_sq_in = '0;
            sum_x_in  = '0;
            sum_y_in  = '0;
            sum_x2_in = '0;
         end
         OP_PAIR_DIV: begin
            if (dx == '0) begin
               status_in = ST_ZERO_DX;
            end else begin
               div_start = 1'b1;
               div_num   = DIV_W'(dy_mag) << 16;
               div_den   = DIV_W'(dx_mag);
            end
            neg_in  = dx[XS] ^ dy[XS];
            sqlo_in = xlo_mag * xlo_mag;
            sqhi_in = xhi_mag * xhi_mag;
         end
         OP_PAIR_END: begin
            if (sl_sat[32]) ov_in = 1'b1;
            sum_a_in  = sum_a_ff + (32+CW)'(sl);
            sum_x_in  = sum_x_ff + (XS+CW)'(xlo_ff) + (XS+CW)'(xhi_ff);
            sum_y_in  = sum_y_ff + (XS+CW)'(ylo_ff) + (XS+CW)'(yhi_ff);
            sum_x2_in = sum_x2_ff + X2W'(sqlo_ff) + X2W'(sqhi_ff);
            idx_in    = idx_ff + SAW'(1);
         end
         OP_A_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(sa_mag);
            div_den   = DIV_W'(m_w);
            neg_in    = sum_a_ff[31+CW];
         end
         OP_A_END: begin
            slope_in = neg_ff ? 32'(-div_quo[31:0]) : div_quo[31:0];
            idx_in   = '0;
         end
         OP_SQ_MUL: prod_in = PW'(dsq);
         OP_SQ_ACC: begin
            sum_sq_in = sum_sq_ff + SSW'(prod_ff[63:0]);
            idx_in    = idx_ff + SAW'(1);
         end
         OP_VAR_DIV: begin
            div_start = 1'b1;
            if (|sum_sq_ff[SSW-1:64]) begin
               ov_in   = 1'b1;
               div_num = '1;
            end else begin
               div_num = sum_sq_ff[63:0];
            end
            div_den = DIV_W'(mm);
         end
         OP_VAR_SQRT: begin
            sq_start = 1'b1;
            sq_in    = div_quo;
         end
         OP_DA_MUL: prod_in = PW'(t_ff * sq_root);
         OP_DA: begin
            if (v12 > (PW-12)'(32'h7FFF_FFFF)) begin
               ov_in   = 1'b1;
               serr_in = 31'h7FFF_FFFF;
            end else begin
               serr_in = v12[30:0];
            end
         end
         OP_XM_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(sx_mag) << 8;
            div_den   = DIV_W'(cnt_ff);
            neg_in    = sum_x_ff[XS+CW-1];
         end
         OP_XM_END: xm_in = neg_ff ? MW'(-div_quo[MW-1:0]) : div_quo[MW-1:0];
         OP_YM_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(sy_mag) << 8;
            div_den   = DIV_W'(cnt_ff);
            neg_in    = sum_y_ff[XS+CW-1];
         end
         OP_YM_END: ym_in = neg_ff ? MW'(-div_quo[MW-1:0]) : div_quo[MW-1:0];
         OP_B_MUL: begin
            prod_in = PW'(amag * xmag);
            pneg_in = slope_ff[31] ^ xm_ff[MW-1];
         end
         OP_B: begin
            if (prod_ff > PW'(64'h4000_0000_0000_0000)) ov_in = 1'b1;
            if (bdiff > $signed(64'h7FFF_FFFF)) begin
               ov_in   = 1'b1;
               icpt_in = 32'h7FFF_FFFF;
            end else if (bdiff < -$signed(64'h8000_0000)) begin
               ov_in   = 1'b1;
               icpt_in = 32'h8000_0000;
            end else begin
               icpt_in = bdiff[31:0];
            end
         end
         OP_MSQ_DIV: begin
            div_start = 1'b1;
            if (|x2e[X2E-1:64]) begin
               ov_in   = 1'b1;
               div_num = '1;
            end else begin
               div_num = x2e[63:0];
            end
            div_den = DIV_W'(cnt_ff);
         end
         OP_MSQ_SQRT: begin
            sq_start = 1'b1;
            if (div_quo > 64'h0000_FFFF_FFFF_FFFF) begin
               ov_in = 1'b1;
               sq_in = '1;
            end else begin
               sq_in = div_quo << 16;
            end
         end
         OP_DB_MUL: prod_in = PW'(serr_ff * sq_root);
         OP_FINISH: begin
            cnt_in = '0;
            ovf_in = 1'b0;
            if (status_ff != ST_OK) begin
               slope_in = '0;
               serr_in  = '0;
               icpt_in  = '0;
               ierr_in  = '0;
               fst_in   = status_ff;
            end else if (v16 > (PW-16)'(32'h7FFF_FFFF)) begin
               ierr_in = 31'h7FFF_FFFF;
               fst_in  = ST_OVF;
            end else begin
               ierr_in = v16[30:0];
               fst_in  = ov_ff ? ST_OVF : ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // Point stores: write on load, registered pair reads
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && cnt_ff != CW'(MAX_POINTS)) begin
         x_mem[AW'(cnt_ff)] <= req_x_sample;
         y_mem[AW'(cnt_ff)] <= req_y_sample;
      end
      if (cmd.op == OP_PAIR_RD) begin
         xlo_ff <= x_mem[lo_addr];
         xhi_ff <= x_mem[hi_addr];
         ylo_ff <= y_mem[lo_addr];
         yhi_ff <= y_mem[hi_addr];
      end
   end

   // Pair slope store
   always_ff @(posedge clock) begin
      if (cmd.op == OP_PAIR_END) s_mem[idx_ff] <= sl;
      if (cmd.op == OP_SQ_RD)    srd_ff        <= s_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         t_ff   <= T_COEF_RESET;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         t_ff   <= t_in;
      end
      idx_ff    <= idx_in;
      sum_a_ff  <= sum_a_in;
      sum_sq_ff <= sum_sq_in;
      sum_x_ff  <= sum_x_in;
      sum_y_ff  <= sum_y_in;
      sum_x2_ff <= sum_x2_in;
      sqlo_ff   <= sqlo_in;
      sqhi_ff   <= sqhi_in;
      neg_ff    <= neg_in;
      pneg_ff   <= pneg_in;
      xm_ff     <= xm_in;
      ym_ff     <= ym_in;
      prod_ff   <= prod_in;
      ov_ff     <= ov_in;
      status_ff <= status_in;
      slope_ff  <= slope_in;
      serr_ff   <= serr_in;
      icpt_ff   <= icpt_in;
      ierr_ff   <= ierr_in;
      fst_ff    <= fst_in;
   end

   psl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   psl_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_in),
      .root     (sq_root),
      .done     (sq_done)
   );

   // Status back to the controller
   always_comb begin
      sts.unit_done = div_done | sq_done;
      sts.pre_bad   = pre_code != ST_OK;
      sts.dx_zero   = dx == '0;
      sts.idx_last  = (CW'(idx_ff) + CW'(1)) == m_w;
   end

   assign rsp_slope           = slope_ff;
   assign rsp_slope_error     = serr_ff;
   assign rsp_intercept       = icpt_ff;
   assign rsp_intercept_error = ierr_ff;
   assign rsp_fit_status      = fst_ff;

endmodule

// ===== rtl/psl_ctrl.sv =====
// Sequencer that walks the fit through load, pair, spread, mean and root phases.
module psl_ctrl
   import psl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last_point,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_stall,
   output logic    rsp_valid
);

   localparam logic [5:0] S_IDLE      = 6'd0;
   localparam logic [5:0] S_INIT      = 6'd1;
   localparam logic [5:0] S_PAIR_RD   = 6'd2;
   localparam logic [5:0] S_PAIR_DIV  = 6'd3;
   localparam logic [5:0] S_PAIR_WAIT = 6'd4;
   localparam logic [5:0] S_PAIR_END  = 6'd5;
   localparam logic [5:0] S_A_DIV     = 6'd6;
   localparam logic [5:0] S_A_WAIT    = 6'd7;
   localparam logic [5:0] S_A_END     = 6'd8;
   localparam logic [5:0] S_SQ_RD     = 6'd9;
   localparam logic [5:0] S_SQ_MUL    = 6'd10;
   localparam logic [5:0] S_SQ_ACC    = 6'd11;
   localparam logic [5:0] S_VAR_DIV   = 6'd12;
   localparam logic [5:0] S_VAR_WAIT  = 6'd13;
   localparam logic [5:0] S_VAR_SQRT  = 6'd14;
   localparam logic [5:0] S_VAR_SWAIT = 6'd15;
   localparam logic [5:0] S_DA_MUL    = 6'd16;
   localparam logic [5:0] S_DA        = 6'd17;
   localparam logic [5:0] S_XM_DIV    = 6'd18;
   localparam logic [5:0] S_XM_WAIT   = 6'd19;
   localparam logic [5:0] S_XM_END    = 6'd20;
   localparam logic [5:0] S_YM_DIV    = 6'd21;
   localparam logic [5:0] S_YM_WAIT   = 6'd22;
   localparam logic [5:0] S_YM_END    = 6'd23;
   localparam logic [5:0] S_B_MUL     = 6'd24;
   localparam logic [5:0] S_B         = 6'd25;
   localparam logic [5:0] S_MSQ_DIV   = 6'd26;
   localparam logic [5:0] S_MSQ_WAIT  = 6'd27;
   localparam logic [5:0] S_MSQ_SQRT  = 6'd28;
   localparam logic [5:0] S_MSQ_SWAIT = 6'd29;
   localparam logic [5:0] S_DB_MUL    = 6'd30;
   localparam logic [5:0] S_FINISH    = 6'd31;
   localparam logic [5:0] S_RESP      = 6'd32;
   localparam logic [5:0] S_RESP_HOLD = 6'd33;

   logic [5:0] state_ff, state_in;

   // Pick the command and the next state
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (req_last_point) state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = sts.pre_bad ? S_FINISH : S_PAIR_RD;
         end
         S_PAIR_RD: begin
            cmd.op   = OP_PAIR_RD;
            state_in = S_PAIR_DIV;
         end
         S_PAIR_DIV: begin
            cmd.op   = OP_PAIR_DIV;
            state_in = sts.dx_zero ? S_FINISH : S_PAIR_WAIT;
         end
         S_PAIR_WAIT: if (sts.unit_done) state_in = S_PAIR_END;
         S_PAIR_END: begin
            cmd.op   = OP_PAIR_END;
            state_in = sts.idx_last ? S_A_DIV : S_PAIR_RD;
         end
         S_A_DIV: begin
            cmd.op   = OP_A_DIV;
            state_in = S_A_WAIT;
         end
         S_A_WAIT: if (sts.unit_done) state_in = S_A_END;
         S_A_END: begin
            cmd.op   = OP_A_END;
            state_in = S_SQ_RD;
         end
         S_SQ_RD: begin
            cmd.op   = OP_SQ_RD;
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            cmd.op   = OP_SQ_MUL;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.op   = OP_SQ_ACC;
            state_in = sts.idx_last ? S_VAR_DIV : S_SQ_RD;
         end
         S_VAR_DIV: begin
            cmd.op   = OP_VAR_DIV;
            state_in = S_VAR_WAIT;
         end
         S_VAR_WAIT: if (sts.unit_done) state_in = S_VAR_SQRT;
         S_VAR_SQRT: begin
            cmd.op   = OP_VAR_SQRT;
            state_in = S_VAR_SWAIT;
         end
         S_VAR_SWAIT: if (sts.unit_done) state_in = S_DA_MUL;
         S_DA_MUL: begin
            cmd.op   = OP_DA_MUL;
            state_in = S_DA;
         end
         S_DA: begin
            cmd.op   = OP_DA;
            state_in = S_XM_DIV;
         end
         S_XM_DIV: begin
            cmd.op   = OP_XM_DIV;
            state_in = S_XM_WAIT;
         end
         S_XM_WAIT: if (sts.unit_done) state_in = S_XM_END;
         S_XM_END: begin
            cmd.op   = OP_XM_END;
            state_in = S_YM_DIV;
         end
         S_YM_DIV: begin
            cmd.op   = OP_YM_DIV;
            state_in = S_YM_WAIT;
         end
         S_YM_WAIT: if (sts.unit_done) state_in = S_YM_END;
         S_YM_END: begin
            cmd.op   = OP_YM_END;
            state_in = S_B_MUL;
         end
         S_B_MUL: begin
            cmd.op   = OP_B_MUL;
            state_in = S_B;
         end
         S_B: begin
            cmd.op   = OP_B;
            state_in = S_MSQ_DIV;
         end
         S_MSQ_DIV: begin
            cmd.op   = OP_MSQ_DIV;
            state_in = S_MSQ_WAIT;
         end
         S_MSQ_WAIT: if (sts.unit_done) state_in = S_MSQ_SQRT;
         S_MSQ_SQRT: begin
            cmd.op   = OP_MSQ_SQRT;
            state_in = S_MSQ_SWAIT;
         end
         S_MSQ_SWAIT: if (sts.unit_done) state_in = S_DB_MUL;
         S_DB_MUL: begin
            cmd.op   = OP_DB_MUL;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op   = OP_FINISH;
            state_in = S_RESP;
         end
         // Load the next set while the result word waits
         S_RESP: begin
            if (req_valid) cmd.op = OP_LOAD;
            if (req_valid && req_last_point) state_in = rsp_stall ? S_RESP_HOLD : S_INIT;
            else if (!rsp_stall)             state_in = S_IDLE;
         end
         // Hold a complete set until the old result word leaves
         S_RESP_HOLD: if (!rsp_stall) state_in = S_INIT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE) && (state_ff != S_RESP);
   assign rsp_valid = (state_ff == S_RESP) || (state_ff == S_RESP_HOLD);

endmodule

// ===== rtl/pairwise_slope_line_fit_core.sv =====
// Method-of-pairs line fit: loads points, then fits slope, intercept and errors.
// Points load one per cycle while req_stall is low. Before the result word, a full fit
//   runs m + 5 divisions of 64 divider steps and 2 roots of 32 steps (m = points/2);
//   a set rejected before pairing runs none, and a zero dx ends the pair phase early.
// Throughput: one fit at a time; the next set loads while a result word waits.
// Reset: synchronous, active high; clears count, overflow mark, sequencer; t = 2.365.
module pairwise_slope_line_fit_core
   import psl_pkg::*;
#(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_x_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_y_sample,
   input  logic                           req_last_point,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_slope,
   output logic [30:0]                    rsp_slope_error,
   output logic signed [31:0]             rsp_intercept,
   output logic [30:0]                    rsp_intercept_error,
   output logic [2:0]                     rsp_fit_status,
   input  logic                           csr_wr_en,
   input  logic [15:0]                    csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   psl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .rsp_stall      (rsp_stall),
      .sts            (sts),
      .cmd            (cmd),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid)
   );

   psl_datapath #(
      .MAX_POINTS   (MAX_POINTS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_x_sample        (req_x_sample),
      .req_y_sample        (req_y_sample),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_slope           (rsp_slope),
      .rsp_slope_error     (rsp_slope_error),
      .rsp_intercept       (rsp_intercept),
      .rsp_intercept_error (rsp_intercept_error),
      .rsp_fit_status      (rsp_fit_status)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the pairwise slope line fit core.
module tb_top;
   import psl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NPTS      = MAX_POINTS_DEF;
   localparam int  CYCLE_CAP = 10000000;
   localparam longint unsigned MUL_CAP = 64'h4000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] slope;
      logic [30:0]        slope_error;
      logic signed [31:0] intercept;
      logic [30:0]        intercept_error;
      logic [2:0]         fit_status;
   } fit_word_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [15:0]       req_x_sample;
   logic signed [15:0]       req_y_sample;
   logic                     req_last_point;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [31:0]       rsp_slope;
   logic [30:0]              rsp_slope_error;
   logic signed [31:0]       rsp_intercept;
   logic [30:0]              rsp_intercept_error;
   logic [2:0]               rsp_fit_status;
   logic                     csr_wr_en;
   logic [15:0]              csr_wr_data;

   // predictor state
   longint                   x_pts [NPTS];
   longint                   y_pts [NPTS];
   int                       pt_count;
   bit                       store_overrun;
   longint unsigned          t_factor;

   fit_word_type             fits_due [$];
   int                       mismatches = 0;
   int                       cycles = 0;
   int                       snd_idle_pct;
   int                       rcv_idle_pct;
   int                       hold_cycles;
   bit                       hold_request;

   pairwise_slope_line_fit_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_sample(req_x_sample), .req_y_sample(req_y_sample),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_slope(rsp_slope), .rsp_slope_error(rsp_slope_error),
      .rsp_intercept(rsp_intercept), .rsp_intercept_error(rsp_intercept_error),
      .rsp_fit_status(rsp_fit_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic longint clip32(longint v, inout bit ov);
      if (v > 64'sd2147483647) begin ov = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin ov = 1; return -64'sd2147483648; end
      return v;
   endfunction

   function automatic longint unsigned clip31(longint unsigned v, inout bit ov);
      if (v > 64'h7FFF_FFFF) begin ov = 1; return 64'h7FFF_FFFF; end
      return v;
   endfunction

   function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                               inout bit ov);
      if (a > ~64'd0 - b) begin ov = 1; return ~64'd0; end
      return a + b;
   endfunction

   function automatic longint mul_sat(longint a, longint b, inout bit ov);
      longint unsigned ma, mb, p;
      bit neg;
      ma = mag(a);
      mb = mag(b);
      neg = (a < 0) != (b < 0);
      if (ma != 0 && mb > MUL_CAP / ma) begin
         ov = 1;
         p = MUL_CAP;
      end else begin
         p = ma * mb;
         if (p > MUL_CAP) begin ov = 1; p = MUL_CAP; end
      end
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v -= res + bt;
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   // line fit over the points held for the current set
   function automatic fit_word_type predict_fit();
      fit_word_type fw;
      int n, m;
      bit ov;
      longint pair_slope [NPTS/2];
      longint sum_a, a_mean, sum_x, sum_y, x_mean, y_mean, b;
      longint unsigned sum_sq, sum_x2, s, da, msq, r, db, d;
      fw = '0;
      n = pt_count;
      m = n / 2;
      ov = 0;
      sum_a = 0; sum_x = 0; sum_y = 0; sum_sq = 0; sum_x2 = 0;
      if (store_overrun) begin fw.fit_status = ST_OVF; return fw; end
      if (n % 2 != 0) begin fw.fit_status = ST_ODD; return fw; end
      if (n < 4) begin fw.fit_status = ST_FEW; return fw; end
      for (int i = 0; i < m; i++)
         if (x_pts[n-1-i] == x_pts[i]) begin fw.fit_status = ST_ZERO_DX; return fw; end
      for (int i = 0; i < m; i++) begin
         pair_slope[i] = clip32(((y_pts[n-1-i] - y_pts[i]) * 65536) /
                                (x_pts[n-1-i] - x_pts[i]), ov);
         sum_a += pair_slope[i];
      end
      a_mean = sum_a / longint'(m);
      for (int i = 0; i < m; i++) begin
         d = mag(pair_slope[i] - a_mean);
         sum_sq = add_sat(sum_sq, d * d, ov);
      end
      s = floor_root(sum_sq / (longint'(m) * longint'(m - 1)));
      da = clip31((t_factor * s) >> 12, ov);
      for (int i = 0; i < n; i++) begin
         sum_x += x_pts[i];
         sum_y += y_pts[i];
         sum_x2 = add_sat(sum_x2, mag(x_pts[i]) * mag(x_pts[i]), ov);
      end
      x_mean = (sum_x * 256) / longint'(n);
      y_mean = (sum_y * 256) / longint'(n);
      b = clip32(y_mean - mul_sat(a_mean, x_mean, ov) / 64'sd65536, ov);
      msq = sum_x2 / longint'(n);
      if (msq > (~64'd0 >> 16)) begin ov = 1; msq = ~64'd0; end
      else msq <<= 16;
      r = floor_root(msq);
      if (r != 0 && da > ~64'd0 / r) begin ov = 1; db = ~64'd0; end
      else db = (da * r) >> 16;
      db = clip31(db, ov);
      fw.slope = a_mean[31:0];
      fw.slope_error = da[30:0];
      fw.intercept = b[31:0];
      fw.intercept_error = db[30:0];
      fw.fit_status = ov ? ST_OVF : ST_OK;
      return fw;
   endfunction

   // update predictor state for one accepted point
   function automatic void take_point(logic signed [15:0] x, logic signed [15:0] y,
                                      logic last);
      if (pt_count < NPTS) begin
         x_pts[pt_count] = longint'(x);
         y_pts[pt_count] = longint'(y);
         pt_count++;
      end else begin
         store_overrun = 1;
      end
      if (last) begin
         fits_due = {fits_due, predict_fit()};
         pt_count = 0;
         store_overrun = 0;
      end
   endfunction

   // offer one point and hold it until accepted
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      int gap;
      if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_x_sample   <= x;
      req_y_sample   <= y;
      req_last_point <= last;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      take_point(x, y, last);
   endtask

   task automatic end_offer();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain all pending fits, then let the block settle
   task automatic wait_drained();
      while (fits_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_t(logic [15:0] val);
      req_valid <= 1'b0;
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      t_factor = 64'(val);
      @(posedge clock);
   endtask

   // result receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_request && hold_cycles == 0) begin
         hold_cycles <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= (hold_cycles > 1);
      end else begin
         rsp_stall <= (rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct);
      end
   end

   // compare each accepted result word with the oldest prediction
   always @(negedge clock) begin
      fit_word_type exp_w, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_slope, rsp_slope_error, rsp_intercept, rsp_intercept_error,
                 rsp_fit_status};
         if (fits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
         end else begin
            exp_w = fits_due.pop_front();
            if (got !== exp_w) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", exp_w, got);
            end
         end
      end
   end

   task automatic send_set(int n, int spread, bit dup_x);
      logic signed [15:0] xs [$];
      logic signed [15:0] x, y;
      for (int i = 0; i < n; i++) begin
         if (spread == 0) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else begin
            x = 16'($urandom_range(2 * spread) - spread);
            y = 16'($urandom_range(2 * spread) - spread);
         end
         // force a zero-dx pair by mirroring the first x
         if (dup_x && n % 2 == 0 && i == n - 1) x = xs[0];
         xs = {xs, x};
         send_point(x, y, i == n - 1);
      end
   endtask

   task automatic test_directed();
      // extremes of the fields
      send_point(-16'sd32768, 16'sd32767, 1'b0);
      send_point(16'sd0, -16'sd1, 1'b0);
      send_point(16'sd1, 16'sd0, 1'b0);
      send_point(16'sd32767, -16'sd32768, 1'b1);
      // clean fit
      send_point(16'sd256, 16'sd512, 1'b0);
      send_point(16'sd512, 16'sd768, 1'b0);
      send_point(16'sd768, 16'sd1100, 1'b0);
      send_point(16'sd1024, 16'sd1280, 1'b1);
      // odd count, single point, too few points
      send_point(16'sd10, 16'sd20, 1'b0);
      send_point(16'sd30, 16'sd40, 1'b0);
      send_point(16'sd50, 16'sd60, 1'b1);
      send_point(16'sd7, 16'sd7, 1'b1);
      send_point(16'sd1, 16'sd2, 1'b0);
      send_point(16'sd3, 16'sd4, 1'b1);
      // zero dx in the inner pair
      send_point(16'sd0, 16'sd1, 1'b0);
      send_point(16'sd5, 16'sd2, 1'b0);
      send_point(16'sd5, 16'sd3, 1'b0);
      send_point(16'sd9, 16'sd4, 1'b1);
      // store full: one point past capacity
      send_set(NPTS + 1, 1000, 1'b0);
      end_offer();
   endtask

   task automatic test_config();
      write_t(16'd0);
      send_set(8, 3000, 1'b0);
      write_t(16'hFFFF);
      send_set(8, 3000, 1'b0);
      send_set(16, 0, 1'b0);
      write_t(16'(T_COEF_RESET));
      end_offer();
   endtask

   // random sets, mostly well formed
   task automatic test_random(int n_items, int s_pct, int r_pct);
      int sent, kind, n;
      sent = 0;
      snd_idle_pct = s_pct;
      rcv_idle_pct = r_pct;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            n = 2 * $urandom_range(2, NPTS / 2);
            send_set(n, ($urandom_range(1) != 0) ? 0 : $urandom_range(1, 4000), 1'b0);
         end else if (kind < 83) begin
            n = 2 * $urandom_range(0, NPTS / 2 - 1) + 1;
            send_set(n, 0, 1'b0);
         end else if (kind < 89) begin
            n = $urandom_range(1, 3);
            send_set(n, 0, 1'b0);
         end else if (kind < 94) begin
            n = $urandom_range(NPTS + 1, NPTS + 4);
            send_set(n, 2000, 1'b0);
         end else begin
            n = 2 * $urandom_range(2, NPTS / 2);
            send_set(n, 500, 1'b1);
         end
         sent += n;
         if ($urandom_range(19) == 0) write_t(16'($urandom));
      end
      end_offer();
   endtask

   // long receiver hold-off while points keep coming
   task automatic test_backpressure();
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      @(negedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      hold_request = 1'b0;
      @(posedge clock);
      repeat (6) send_set(8, 1500, 1'b0);
      end_offer();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_sample = '0;
      req_y_sample = '0;
      req_last_point = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      pt_count = 0;
      store_overrun = 0;
      t_factor = 64'(T_COEF_RESET);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config();
      test_random(530, 27, 63);
      test_random(530, 63, 27);
      test_backpressure();
      test_random(530, 0, 0);

      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && fits_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== pairwise_slope_line_fit_core.f =====
rtl/psl_pkg.sv
rtl/psl_div.sv
rtl/psl_sqrt.sv
rtl/psl_datapath.sv
rtl/psl_ctrl.sv
rtl/pairwise_slope_line_fit_core.sv
verif/tb_top.sv
